// ===== src/cmx_pkg.sv =====
// ----------------------------------------------------------------------------
// cmx_pkg - shared types and constants of the two-channel LED mixer
// Field widths, register indexes and the status/command words that pass
// between the sequencer and its bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package cmx_pkg;

    localparam int KELVIN_W = 16;
    localparam int MARGIN_W = 10;
    localparam int DUTY_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W    = 32;
    localparam int STEP_W   = 5;
    localparam int GAMMA_DIVISOR = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_WARM_KELVIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_KELVIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_MARGIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL    = 2'd3;

    localparam logic [KELVIN_W-1:0] RST_WARM_KELVIN = 16'd2700;
    localparam logic [KELVIN_W-1:0] RST_COLD_KELVIN = 16'd6500;
    localparam logic [MARGIN_W-1:0] RST_SNAP_MARGIN = 10'd75;
    localparam logic [DUTY_W-1:0]   RST_PWM_FULL    = 16'd1023;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

endpackage

// ===== src/cmx_in_if.sv =====
// ----------------------------------------------------------------------------
// cmx_in_if - request channel of the LED mixer
// Carries on/off, the requested level and the colour temperature of one word.
// ----------------------------------------------------------------------------
interface cmx_in_if #(
    parameter int FRAC_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         light_on;
    logic [FRAC_BITS:0]           level;
    logic [cmx_pkg::KELVIN_W-1:0] color_temp;

    modport source (output valid, output light_on, output level, output color_temp,
                    input ready);
    modport sink   (input valid, input light_on, input level, input color_temp,
                    output ready);
endinterface

// ===== src/cmx_out_if.sv =====
// ----------------------------------------------------------------------------
// cmx_out_if - duty channel of the LED mixer
// Carries the warm and cold PWM duties and the rejected-level flag.
// ----------------------------------------------------------------------------
interface cmx_out_if;
    logic                       valid;
    logic                       ready;
    logic [cmx_pkg::DUTY_W-1:0] warm_duty;
    logic [cmx_pkg::DUTY_W-1:0] cold_duty;
    logic                       level_rejected;

    modport source (output valid, output warm_duty, output cold_duty,
                    output level_rejected, input ready);
    modport sink   (input valid, input warm_duty, input cold_duty,
                    input level_rejected, output ready);
endinterface

// ===== src/cmx_mul.sv =====
// ----------------------------------------------------------------------------
// cmx_mul - bit-serial shift-add multiplier
// One multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module cmx_mul #(
    parameter int MW = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MW-1:0]       i_a,
    input  logic [MW-1:0]       i_b,
    output cmx_pkg::t_unit_sts  o_sts,
    output logic [2*MW-1:0]     o_prod
);
    localparam int CW = $clog2(MW + 1);

    logic [2*MW-1:0] r_p;
    logic [MW-1:0]   r_a;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    logic [MW:0]     sum;

    // add the multiplicand into the upper half when the current bit is set
    assign sum = {1'b0, r_p[2*MW-1:MW]} + (r_p[0] ? {1'b0, r_a} : {(MW+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= CW'(MW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{MW{1'b0}}, i_b};
        end else if (r_cnt != '0) begin
            r_p <= {sum, r_p[MW-1:1]};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_prod     = r_p;
endmodule

// ===== src/cmx_div.sv =====
// ----------------------------------------------------------------------------
// cmx_div - bit-serial restoring divider
// Shifts one dividend bit into the partial remainder per cycle and yields
// one quotient bit per cycle. The starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
module cmx_div #(
    parameter int LOW = 19
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cmx_pkg::t_div_cmd               i_cmd,
    input  logic [cmx_pkg::DIV_W-1:0]       i_rem_init,
    input  logic [LOW-1:0]                  i_lo,
    input  logic [cmx_pkg::DIV_W-1:0]       i_divisor,
    output cmx_pkg::t_unit_sts              o_sts,
    output logic [LOW-1:0]                  o_quot
);
    localparam int DW = cmx_pkg::DIV_W;
    localparam int SW = cmx_pkg::STEP_W;

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [LOW-1:0] r_lo;
    logic [LOW-1:0] r_quot;
    logic [SW-1:0] r_cnt;
    logic          r_done;
    logic [DW:0]   rem2;
    logic [DW:0]   diff;
    logic          ge;

    assign rem2 = {r_rem, r_lo[LOW-1]};
    assign diff = rem2 - {1'b0, r_div};
    assign ge   = (rem2 >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == SW'(1));
            if (i_cmd.start) begin
                r_cnt <= i_cmd.steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= i_rem_init;
            r_div  <= i_divisor;
            r_lo   <= i_lo;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            // subtract where it fits, otherwise keep the shifted remainder
            r_rem  <= ge ? diff[DW-1:0] : rem2[DW-1:0];
            r_lo   <= {r_lo[LOW-2:0], 1'b0};
            r_quot <= {r_quot[LOW-2:0], ge};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;
endmodule

// ===== src/cct_two_channel_led_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// cct_two_channel_led_mixer_unit - tunable-white warm/cold LED duty mixer
// Applies a gamma curve to the requested level, forms the mired-mix cold
// share and scales both channel shares into PWM duties.
// ----------------------------------------------------------------------------
// One request word is taken at a time and gives one duty word. All products
// and quotients run through a single bit-serial multiplier of
// MW = max(FRAC_BITS+1, 16) bits and a bit-serial divider, each about one bit
// per cycle. With the lamp off the level is still squared or scaled by 0.15,
// unless it is rejected. A full mix takes seven products and one quotient with
// a squared level and six products and two quotients with a scaled one; a
// snapped share skips the quotient and two of the products. A new request is
// taken as soon as the duty word of the previous one sits in the output
// register, even if it has not yet been taken.
module cct_two_channel_led_mixer_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cmx_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cmx_pkg::CFG_W-1:0]           i_cfg_data,
    cmx_in_if.sink                              i_in,
    cmx_out_if.source                           o_out
);
    localparam int LW  = FRAC_BITS + 1;
    localparam int MW  = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
    localparam int DLW = FRAC_BITS + 3;
    localparam int GW  = FRAC_BITS + 6;
    localparam int KW  = cmx_pkg::KELVIN_W;
    localparam int DW  = cmx_pkg::DIV_W;
    localparam int SW  = cmx_pkg::STEP_W;
    localparam int UW  = cmx_pkg::DUTY_W;

    localparam logic [LW-1:0] ONE       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [GW-1:0] THREE_ONE = GW'(3) << FRAC_BITS;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_GAM    = 4'd1;
    localparam logic [3:0] ST_GAM_MW = 4'd2;
    localparam logic [3:0] ST_GAM_DW = 4'd3;
    localparam logic [3:0] ST_SHARE  = 4'd4;
    localparam logic [3:0] ST_NUM_W  = 4'd5;
    localparam logic [3:0] ST_DEN    = 4'd6;
    localparam logic [3:0] ST_DEN_W  = 4'd7;
    localparam logic [3:0] ST_QUO    = 4'd8;
    localparam logic [3:0] ST_QUO_W  = 4'd9;
    localparam logic [3:0] ST_DA     = 4'd10;
    localparam logic [3:0] ST_DA_W   = 4'd11;
    localparam logic [3:0] ST_DB     = 4'd12;
    localparam logic [3:0] ST_DB_W   = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    // configuration
    logic [KW-1:0]                r_warm_k;
    logic [KW-1:0]                r_cold_k;
    logic [cmx_pkg::MARGIN_W-1:0] r_margin;
    logic [UW-1:0]                r_pwm_full;

    // sequencer and datapath
    logic [3:0]      r_state;
    logic            r_on;
    logic [LW-1:0]   r_level;
    logic [KW-1:0]   r_ct;
    logic            r_rejected;
    logic [LW-1:0]   r_kept;
    logic [LW-1:0]   r_share;
    logic [2*KW-1:0] r_num;
    logic [2*KW-1:0] r_den;
    logic [LW-1:0]   r_scaled;
    logic            r_chan;
    logic [UW-1:0]   r_warm_duty;
    logic [UW-1:0]   r_cold_duty;

    // output register
    logic            r_out_valid;
    logic [UW-1:0]   r_out_warm;
    logic [UW-1:0]   r_out_cold;
    logic            r_out_rej;

    // arithmetic units
    logic               mul_start;
    logic [MW-1:0]      mul_a;
    logic [MW-1:0]      mul_b;
    cmx_pkg::t_unit_sts mul_sts;
    logic [2*MW-1:0]    mul_prod;
    cmx_pkg::t_div_cmd  div_cmd;
    logic [DW-1:0]      div_rem;
    logic [DLW-1:0]     div_lo;
    logic [DW-1:0]      div_den;
    cmx_pkg::t_unit_sts div_sts;
    logic [DLW-1:0]     div_quot;

    logic [GW-1:0]   level_x20;
    logic [DLW-1:0]  level_x3;
    logic            gamma_square;
    logic [KW:0]     warm_plus_m;
    logic [KW:0]     ct_plus_m;
    logic [LW-1:0]   chan_share;
    logic            out_free;

    assign level_x20    = (GW'(r_level) << 4) + (GW'(r_level) << 2);
    assign level_x3     = (DLW'(r_level) << 1) + DLW'(r_level);
    assign gamma_square = (level_x20 > THREE_ONE);
    assign warm_plus_m  = {1'b0, r_warm_k} + (KW+1)'(r_margin);
    assign ct_plus_m    = {1'b0, r_ct} + (KW+1)'(r_margin);
    assign chan_share   = r_chan ? r_share : (ONE - r_share);
    assign out_free     = !r_out_valid || o_out.ready;

    cmx_mul #(.MW(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    cmx_div #(.LOW(DLW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_rem_init (div_rem),
        .i_lo       (div_lo),
        .i_divisor  (div_den),
        .o_sts      (div_sts),
        .o_quot     (div_quot)
    );

    // operand selection for the shared units
    always_comb begin
        mul_start     = 1'b0;
        mul_a         = MW'(r_level);
        mul_b         = MW'(r_level);
        div_cmd.start = 1'b0;
        div_cmd.steps = SW'(DLW);
        div_rem       = '0;
        div_lo        = level_x3;
        div_den       = DW'(cmx_pkg::GAMMA_DIVISOR);
        case (r_state)
            ST_GAM: begin
                mul_start     = !r_rejected && gamma_square;
                div_cmd.start = !r_rejected && !gamma_square;
            end
            ST_SHARE: begin
                mul_start = r_on && (r_cold_k > r_warm_k)
                            && ({1'b0, r_ct} > warm_plus_m)
                            && (ct_plus_m < {1'b0, r_cold_k});
                mul_a     = MW'(r_cold_k);
                mul_b     = MW'(r_ct - r_warm_k);
            end
            ST_DEN: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_ct);
                mul_b     = MW'(r_cold_k - r_warm_k);
            end
            ST_QUO: begin
                div_cmd.start = (r_num < r_den);
                div_cmd.steps = SW'(FRAC_BITS);
                div_rem       = DW'(r_num);
                div_lo        = '0;
                div_den       = DW'(r_den);
            end
            ST_DA: begin
                mul_start = 1'b1;
                mul_a     = MW'(chan_share);
                mul_b     = MW'(r_kept);
            end
            ST_DB: begin
                mul_start = 1'b1;
                mul_a     = MW'(r_scaled);
                mul_b     = MW'(r_pwm_full);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_k   <= cmx_pkg::RST_WARM_KELVIN;
            r_cold_k   <= cmx_pkg::RST_COLD_KELVIN;
            r_margin   <= cmx_pkg::RST_SNAP_MARGIN;
            r_pwm_full <= cmx_pkg::RST_PWM_FULL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cmx_pkg::CFG_WARM_KELVIN: r_warm_k   <= i_cfg_data;
                cmx_pkg::CFG_COLD_KELVIN: r_cold_k   <= i_cfg_data;
                cmx_pkg::CFG_SNAP_MARGIN: r_margin   <= i_cfg_data[cmx_pkg::MARGIN_W-1:0];
                cmx_pkg::CFG_PWM_FULL:    r_pwm_full <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kept      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= ST_GAM;
                    end
                end
                ST_GAM: begin
                    if (r_rejected) begin
                        r_state <= ST_SHARE;
                    end else if (gamma_square) begin
                        r_state <= ST_GAM_MW;
                    end else begin
                        r_state <= ST_GAM_DW;
                    end
                end
                ST_GAM_MW: begin
                    if (mul_sts.done) begin
                        r_kept  <= mul_prod[FRAC_BITS +: LW];
                        r_state <= ST_SHARE;
                    end
                end
                ST_GAM_DW: begin
                    if (div_sts.done) begin
                        r_kept  <= div_quot[LW-1:0];
                        r_state <= ST_SHARE;
                    end
                end
                ST_SHARE: begin
                    if (!r_on) begin
                        r_state <= ST_OUT;
                    end else if (mul_start) begin
                        r_state <= ST_NUM_W;
                    end else begin
                        r_state <= ST_DA;
                    end
                end
                ST_NUM_W: begin
                    if (mul_sts.done) begin
                        r_state <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    r_state <= ST_DEN_W;
                end
                ST_DEN_W: begin
                    if (mul_sts.done) begin
                        r_state <= ST_QUO;
                    end
                end
                ST_QUO: begin
                    r_state <= div_cmd.start ? ST_QUO_W : ST_DA;
                end
                ST_QUO_W: begin
                    if (div_sts.done) begin
                        r_state <= ST_DA;
                    end
                end
                ST_DA: begin
                    r_state <= ST_DA_W;
                end
                ST_DA_W: begin
                    if (mul_sts.done) begin
                        r_state <= ST_DB;
                    end
                end
                ST_DB: begin
                    r_state <= ST_DB_W;
                end
                ST_DB_W: begin
                    if (mul_sts.done) begin
                        r_state <= r_chan ? ST_OUT : ST_DA;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_on        <= i_in.light_on;
                r_level     <= i_in.level;
                r_ct        <= i_in.color_temp;
                r_rejected  <= i_in.level[FRAC_BITS] && (|i_in.level[FRAC_BITS-1:0]);
                r_chan      <= 1'b0;
                r_warm_duty <= '0;
                r_cold_duty <= '0;
            end
            ST_SHARE: begin
                // snap to one channel near or beyond either LED temperature, or to warm if cold <= warm
                if (r_cold_k <= r_warm_k || {1'b0, r_ct} <= warm_plus_m) begin
                    r_share <= '0;
                end else begin
                    r_share <= ONE;
                end
            end
            ST_NUM_W: begin
                if (mul_sts.done) begin
                    r_num <= mul_prod[2*KW-1:0];
                end
            end
            ST_DEN_W: begin
                if (mul_sts.done) begin
                    r_den <= mul_prod[2*KW-1:0];
                end
            end
            ST_QUO: begin
                if (!div_cmd.start) begin
                    r_share <= ONE;
                end
            end
            ST_QUO_W: begin
                if (div_sts.done) begin
                    r_share <= {1'b0, div_quot[FRAC_BITS-1:0]};
                end
            end
            ST_DA_W: begin
                if (mul_sts.done) begin
                    r_scaled <= mul_prod[FRAC_BITS +: LW];
                end
            end
            ST_DB_W: begin
                if (mul_sts.done) begin
                    if (r_chan) begin
                        r_cold_duty <= mul_prod[FRAC_BITS +: UW];
                    end else begin
                        r_warm_duty <= mul_prod[FRAC_BITS +: UW];
                    end
                    r_chan <= 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_warm <= r_warm_duty;
                    r_out_cold <= r_cold_duty;
                    r_out_rej  <= r_rejected;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.warm_duty      = r_out_warm;
    assign o_out.cold_duty      = r_out_cold;
    assign o_out.level_rejected = r_out_rej;

    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!mul_sts.busy && !div_sts.busy))
        else $error("arithmetic unit busy while idle");

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_sts.done |-> (r_state == ST_GAM_MW || r_state == ST_NUM_W
                          || r_state == ST_DEN_W || r_state == ST_DA_W
                          || r_state == ST_DB_W))
        else $error("multiplier finished outside a wait state");

    a_kept_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= ONE)
        else $error("kept brightness above full scale");

    a_out_loaded_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !out_free) |=> (r_state == ST_OUT))
        else $error("left output state while the output register was full");
endmodule

// ===== tb/tb_cct_two_channel_led_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_cct_two_channel_led_mixer_unit - self-checking bench of the LED mixer
// Offers request words on the input channel and predicts every duty word in
// step with the input handshakes. Each duty word on the output channel is
// compared against the oldest prediction. Both channels idle at random, and
// the register settings are changed only while the mixer is drained.
// ----------------------------------------------------------------------------
module tb_cct_two_channel_led_mixer_unit;

    localparam int FRAC_BITS = 16;
    localparam int KW = cmx_pkg::KELVIN_W;
    localparam int UW = cmx_pkg::DUTY_W;
    localparam int MGW = cmx_pkg::MARGIN_W;
    localparam int CIW = cmx_pkg::CFG_IDX_W;
    localparam int CDW = cmx_pkg::CFG_W;
    localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
    localparam int LEVEL_MAX = (1 << (FRAC_BITS + 1)) - 1;
    localparam int GAMMA_KNEE = int'(3 * ONE / 20);
    localparam int KELVIN_LO = 1000;
    localparam int KELVIN_HI = 40000;
    localparam int HOLD_AT = 1000;
    localparam int HOLD_LEN = 600;
    localparam int DRAIN_CYCLES = 200;

    typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FREE} t_pace;

    typedef struct packed {
        logic                on;
        logic [FRAC_BITS:0]  level;
        logic [KW-1:0]       ct;
    } t_req_word;

    typedef struct packed {
        logic [UW-1:0] warm;
        logic [UW-1:0] cold;
        logic          rejected;
    } t_duty_word;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_we;
    logic [CIW-1:0] cfg_idx;
    logic [CDW-1:0] cfg_data;

    cmx_in_if #(.FRAC_BITS(FRAC_BITS)) req_ch ();
    cmx_out_if                         duty_ch ();

    cct_two_channel_led_mixer_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (req_ch),
        .o_out      (duty_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register shadow and kept brightness of the predictor
    logic [KW-1:0]       warm_k;
    logic [KW-1:0]       cold_k;
    logic [MGW-1:0]      margin_k;
    logic [UW-1:0]       pwm_fs;
    logic [FRAC_BITS:0]  kept_level = '0;

    t_req_word  req_pending_q[$];
    t_duty_word duty_expect_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int words_in = 0;
    int words_out = 0;
    int hold_left;
    logic hold_used;
    int error_count = 0;
    int levels_rejected = 0;
    int lamp_off_words = 0;
    int snapped_words = 0;
    int settings_used;

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic longint unsigned mired_cold_part(input logic [KW-1:0] ct);
        longint unsigned w;
        longint unsigned c;
        longint unsigned m;
        longint unsigned t;
        longint unsigned s;
        w = warm_k;
        c = cold_k;
        m = margin_k;
        t = ct;
        if (c <= w) return 0;
        if (t <= w + m) return 0;
        if (t + m >= c) return ONE;
        s = c * (t - w) * ONE / (t * (c - w));
        return (s > ONE) ? ONE : s;
    endfunction

    function automatic logic [UW-1:0] scale_to_duty(input longint unsigned part);
        longint unsigned lit;
        lit = (part * kept_level) >> FRAC_BITS;
        return UW'((lit * pwm_fs) >> FRAC_BITS);
    endfunction

    task automatic predict_duty(input t_req_word w);
        longint unsigned lv;
        longint unsigned part;
        t_duty_word e;
        lv = w.level;
        e = '0;
        if (lv > ONE) begin
            e.rejected = 1'b1;
            levels_rejected++;
        end else if (lv * 20 > 3 * ONE) begin
            kept_level = (FRAC_BITS+1)'((lv * lv) >> FRAC_BITS);
        end else begin
            kept_level = (FRAC_BITS+1)'(lv * 3 / 20);
        end
        if (w.on) begin
            part = mired_cold_part(w.ct);
            if (part == 0 || part == ONE) snapped_words++;
            e.warm = scale_to_duty(ONE - part);
            e.cold = scale_to_duty(part);
        end else begin
            lamp_off_words++;
        end
        duty_expect_q.push_back(e);
    endtask

    // driver: predict on every accepted word, then load the next one
    always @(posedge clk) begin : req_driver
        t_req_word acc;
        t_req_word nxt;
        if (!rst_n) begin
            req_ch.valid      <= 1'b0;
            req_ch.light_on   <= 1'b0;
            req_ch.level      <= '0;
            req_ch.color_temp <= KW'(KELVIN_LO);
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                acc.on    = req_ch.light_on;
                acc.level = req_ch.level;
                acc.ct    = req_ch.color_temp;
                predict_duty(acc);
                words_in <= words_in + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = req_pending_q.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.light_on   <= nxt.on;
                    req_ch.level      <= nxt.level;
                    req_ch.color_temp <= nxt.ct;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // one long hold-off of the output channel while requests keep coming
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && words_in >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic check_duty_word();
        t_duty_word e;
        if (duty_expect_q.size() == 0) begin
            flag_error($sformatf("duty word warm=%0d cold=%0d rej=%0d with nothing expected",
                                 duty_ch.warm_duty, duty_ch.cold_duty,
                                 duty_ch.level_rejected));
        end else begin
            e = duty_expect_q.pop_front();
            if (duty_ch.warm_duty !== e.warm)
                flag_error($sformatf("word %0d warm_duty %0d, want %0d",
                                     words_out, duty_ch.warm_duty, e.warm));
            if (duty_ch.cold_duty !== e.cold)
                flag_error($sformatf("word %0d cold_duty %0d, want %0d",
                                     words_out, duty_ch.cold_duty, e.cold));
            if (duty_ch.level_rejected !== e.rejected)
                flag_error($sformatf("word %0d level_rejected %0b, want %0b",
                                     words_out, duty_ch.level_rejected, e.rejected));
        end
    endtask

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            duty_ch.ready <= 1'b0;
        end else begin
            if (duty_ch.valid && duty_ch.ready) begin
                check_duty_word();
                words_out <= words_out + 1;
            end
            duty_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic set_pace(input t_pace p);
        case (p)
            PACE_SLOW_SINK: begin
                send_idle_pct = 14;
                recv_idle_pct = 67;
            end
            PACE_SLOW_SOURCE: begin
                send_idle_pct = 67;
                recv_idle_pct = 14;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic push_req(input logic on, input int level, input int ct);
        t_req_word w;
        w.on    = on;
        w.level = level[FRAC_BITS:0];
        w.ct    = ct[KW-1:0];
        req_pending_q.push_back(w);
    endtask

    function automatic int clamp_kelvin(input int k);
        if (k < KELVIN_LO) return KELVIN_LO;
        if (k > KELVIN_HI) return KELVIN_HI;
        return k;
    endfunction

    task automatic queue_random(input int n);
        int lv;
        int ct;
        int w;
        int c;
        int m;
        int lo;
        int hi;
        w = warm_k;
        c = cold_k;
        m = margin_k;
        lo = ((w < c) ? w : c) - 100;
        hi = ((w > c) ? w : c) + 100;
        if (lo < 0) lo = 0;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: lv = int'($urandom_range(int'(ONE), 0));
                11, 12: lv = int'($urandom_range(GAMMA_KNEE + 8, 0));
                13: begin
                    case ($urandom_range(3))
                        0: lv = 0;
                        1: lv = GAMMA_KNEE;
                        2: lv = GAMMA_KNEE + 1;
                        default: lv = int'(ONE);
                    endcase
                end
                14, 15, 16, 17: lv = int'($urandom_range(LEVEL_MAX, int'(ONE) + 1));
                default: lv = int'($urandom_range(LEVEL_MAX, 0));
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3: ct = clamp_kelvin(int'($urandom_range(hi, lo)));
                4: ct = clamp_kelvin(w + m + int'($urandom_range(4)) - 2);
                5: ct = clamp_kelvin(c - m + int'($urandom_range(4)) - 2);
                default: ct = int'($urandom_range(KELVIN_HI, KELVIN_LO));
            endcase
            push_req($urandom_range(99) < 88, lv, ct);
        end
    endtask

    task automatic wait_drained();
        while (req_pending_q.size() != 0 || req_ch.valid || duty_expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cmx_pkg::CFG_WARM_KELVIN: warm_k   = data;
            cmx_pkg::CFG_COLD_KELVIN: cold_k   = data;
            cmx_pkg::CFG_SNAP_MARGIN: margin_k = data[MGW-1:0];
            cmx_pkg::CFG_PWM_FULL:    pwm_fs   = data;
            default: ;
        endcase
    endtask

    task automatic reconfigure(input int w, input int c, input int m, input int p);
        wait_drained();
        write_reg(cmx_pkg::CFG_WARM_KELVIN, w[CDW-1:0]);
        write_reg(cmx_pkg::CFG_COLD_KELVIN, c[CDW-1:0]);
        write_reg(cmx_pkg::CFG_SNAP_MARGIN, m[CDW-1:0]);
        write_reg(cmx_pkg::CFG_PWM_FULL, p[CDW-1:0]);
        @(negedge clk);
        settings_used++;
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = cmx_pkg::CFG_WARM_KELVIN;
        cfg_data          = '0;
        warm_k     = cmx_pkg::RST_WARM_KELVIN;
        cold_k     = cmx_pkg::RST_COLD_KELVIN;
        margin_k   = cmx_pkg::RST_SNAP_MARGIN;
        pwm_fs     = cmx_pkg::RST_PWM_FULL;
        settings_used = 1;
        set_pace(PACE_SLOW_SINK);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: gamma knee, level limits, lamp off, snap band edges
        push_req(1'b1, 0, 4000);
        push_req(1'b1, 1, 4000);
        push_req(1'b1, GAMMA_KNEE, 4000);
        push_req(1'b1, GAMMA_KNEE + 1, 4000);
        push_req(1'b1, int'(ONE), 4000);
        push_req(1'b1, int'(ONE) + 1, 4000);
        push_req(1'b1, LEVEL_MAX, 4000);
        push_req(1'b0, 32768, 5000);
        push_req(1'b0, LEVEL_MAX, 5000);
        push_req(1'b1, int'(ONE), KELVIN_LO);
        push_req(1'b1, int'(ONE), KELVIN_HI);
        push_req(1'b1, int'(ONE), 2775);
        push_req(1'b1, int'(ONE), 2776);
        push_req(1'b1, int'(ONE), 6425);
        push_req(1'b1, int'(ONE), 6424);
        push_req(1'b1, int'(ONE), 2700);
        push_req(1'b1, int'(ONE), 6500);
        push_req(1'b1, 65535, 32767);
        push_req(1'b1, 43690, 3333);
        push_req(1'b1, 12345, 5555);

        reconfigure(1000, 40000, 1000, 65535);
        queue_random(300);

        set_pace(PACE_SLOW_SOURCE);
        reconfigure(2700, 6500, 0, 1);
        queue_random(300);

        // cold LED below the warm one: everything goes to the warm channel
        reconfigure(6500, 2700, 75, 4095);
        push_req(1'b1, int'(ONE), KELVIN_LO);
        push_req(1'b1, int'(ONE), 4000);
        push_req(1'b1, int'(ONE), KELVIN_HI);
        push_req(1'b1, 20000, 6500);
        push_req(1'b0, int'(ONE), 4000);
        queue_random(60);

        reconfigure(2200, 5700, 511, 0);
        queue_random(40);

        set_pace(PACE_FREE);
        reconfigure(4000, 4000, 0, 1023);
        queue_random(40);

        reconfigure(1800, 6000, 200, 1000);
        queue_random(688);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (duty_expect_q.size() != 0)
            flag_error($sformatf("%0d duty words never arrived", duty_expect_q.size()));
        $display("Run covered %0d request words and %0d duty words over %0d register settings",
                 words_in, words_out, settings_used);
        $display("  %0d levels rejected, %0d with lamp off, %0d shares snapped, %0d errors",
                 levels_rejected, lamp_off_words, snapped_words, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout: %0d words in, %0d out", words_in, words_out);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
